// ----- rtl/row_minmax_uint8_quantizer_unit_macros.svh -----
// assertion macros for the row min/max quantizer
// no dependencies; included by the modules that carry assertions
`ifndef ROW_MINMAX_UINT8_QUANTIZER_UNIT_MACROS_SVH
`define ROW_MINMAX_UINT8_QUANTIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rmq_pkg.sv -----
// shared constants and types for the row min/max quantizer
// no dependencies
package rmq_pkg;

    localparam int DATA_W          = 32;
    localparam int CODE_W          = 8;
    localparam int SCALE_W         = DATA_W + 1;
    localparam int NUM_W           = DATA_W + CODE_W;
    localparam int ROW_LEN_MAX_DEF = 64;

    localparam logic [DATA_W-1:0] MIN_INIT = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MAX_INIT = {1'b1, {(DATA_W-1){1'b0}}};

    // control from the sequencer to the code divider
    typedef struct packed {
        logic start;
        logic take;
    } div_ctrl_t;

endpackage

// ----- rtl/rmq_row_mem.sv -----
// row buffer: one write port, one read port with registered read data
// depends on rmq_pkg
module rmq_row_mem #(
    parameter int DEPTH  = rmq_pkg::ROW_LEN_MAX_DEF,
    parameter int ADDR_W = 6
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [rmq_pkg::DATA_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [rmq_pkg::DATA_W-1:0]  rd_data
);
    import rmq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rmq_code_div.sv -----
// iterative code divider: floor(diff * 255 / range), one quotient bit per cycle
// depends on rmq_pkg
module rmq_code_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rmq_pkg::div_ctrl_t          ctrl,
    input  logic [rmq_pkg::DATA_W-1:0]  diff,
    input  logic [rmq_pkg::DATA_W-1:0]  range,
    output logic                        done,
    output logic [rmq_pkg::CODE_W-1:0]  quot
);
    import rmq_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV,
        D_DONE
    } dstate_t;

    localparam int STEP_W = $clog2(CODE_W);

    dstate_t           state_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0] den_reg;
    logic [CODE_W-1:0] quot_reg;
    logic [STEP_W-1:0] step_reg;

    logic [NUM_W-1:0]  trial;
    logic [NUM_W-1:0]  num_x255;

    always_comb
    begin
        trial    = {{CODE_W{1'b0}}, den_reg} << step_reg;
        // diff * 255 as (diff << 8) - diff
        num_x255 = {num_reg[DATA_W-1:0], {CODE_W{1'b0}}} - num_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            num_reg   <= '0;
            den_reg   <= '0;
            quot_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        num_reg  <= {{CODE_W{1'b0}}, diff};
                        den_reg  <= range;
                        quot_reg <= '0;
                        // zero range gives code zero without dividing
                        state_reg <= (range == '0) ? D_DONE : D_MUL;
                    end
                end
                D_MUL:
                begin
                    num_reg   <= num_x255;
                    step_reg  <= STEP_W'(CODE_W - 1);
                    state_reg <= D_DIV;
                end
                D_DIV:
                begin
                    if (num_reg >= trial)
                    begin
                        num_reg            <= num_reg - trial;
                        quot_reg[step_reg] <= 1'b1;
                    end
                    if (step_reg == '0)
                    begin
                        state_reg <= D_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                D_DONE:
                begin
                    if (ctrl.take)
                    begin
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == D_DONE);
    assign quot = quot_reg;

endmodule

// ----- rtl/row_minmax_uint8_quantizer_unit.sv -----
// Row min/max uint8 quantizer. Samples (signed Q16.16) are taken one per cycle, while
// sample_stall is low, into a row buffer as the running minimum and maximum are tracked.
// A beat with last_in_row set, or the beat that fills ROW_LEN_MAX entries, closes the row:
// the block then computes the range and scale = floor(range * 256 / 255) with a byte-serial
// divide by 255, and emits one code per stored sample in arrival order, each carrying scale
// (units of 2^-24), the row minimum as row_offset and last_code on the final one. Each code
// passes through loading the divider from the buffer read data, the multiply by 255, the
// one-bit-per-cycle divide by the range and hand-off to the output register; a zero-range
// row skips the multiply and divide. Output stalls hold the hand-off. sample_stall rises
// after the closing beat and stays high until the row's last code is in the output register.
// depends on rmq_pkg, rmq_row_mem, rmq_code_div and the assertion macro header
`include "row_minmax_uint8_quantizer_unit_macros.svh"

module row_minmax_uint8_quantizer_unit #(
    parameter int ROW_LEN_MAX = rmq_pkg::ROW_LEN_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic signed [rmq_pkg::DATA_W-1:0]  sample,
    input  logic                               last_in_row,
    output logic                               code_valid,
    input  logic                               code_stall,
    output logic [rmq_pkg::CODE_W-1:0]         code,
    output logic [rmq_pkg::SCALE_W-1:0]        scale,
    output logic signed [rmq_pkg::DATA_W-1:0]  row_offset,
    output logic                               last_code
);
    import rmq_pkg::*;

    localparam int CNT_W  = $clog2(ROW_LEN_MAX + 1);
    localparam int ADDR_W = (ROW_LEN_MAX > 1) ? $clog2(ROW_LEN_MAX) : 1;

    typedef enum logic [2:0] {
        S_FILL,
        S_RANGE,
        S_SCALE,
        S_SCALE_ADD,
        S_START,
        S_WAIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   fill_cnt_reg;
    logic [CNT_W-1:0]   emit_idx_reg;
    logic [DATA_W-1:0]  min_reg;
    logic [DATA_W-1:0]  max_reg;
    logic [DATA_W-1:0]  range_reg;
    logic [DATA_W-1:0]  qacc_reg;
    logic [7:0]         rem_reg;
    logic [1:0]         scl_cnt_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic               code_valid_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [SCALE_W-1:0] code_scale_reg;
    logic [DATA_W-1:0]  code_offset_reg;
    logic               last_code_reg;

    logic               accept;
    logic [CNT_W-1:0]   fill_cnt_next;
    logic               row_end;
    logic [DATA_W-1:0]  min_next;
    logic [DATA_W-1:0]  max_next;
    logic [DATA_W:0]    range_wide;

    logic [15:0]        scl_n;
    logic [15:0]        scl_sum;
    logic [7:0]         scl_q;
    logic [15:0]        scl_rem;

    logic [CNT_W-1:0]   emit_idx_next;
    logic               is_last;
    logic               slot_free;
    logic               xfer;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DATA_W-1:0]  rd_data;
    logic [DATA_W:0]    diff_wide;

    div_ctrl_t          div_ctrl;
    logic               div_done;
    logic [CODE_W-1:0]  div_quot;

    always_comb
    begin
        accept        = sample_valid && !sample_stall;
        fill_cnt_next = fill_cnt_reg + 1'b1;
        row_end       = last_in_row || (fill_cnt_next == CNT_W'(ROW_LEN_MAX));
        min_next      = ($signed(sample) < $signed(min_reg)) ? sample : min_reg;
        max_next      = ($signed(sample) > $signed(max_reg)) ? sample : max_reg;
        range_wide    = {max_reg[DATA_W-1], max_reg} - {min_reg[DATA_W-1], min_reg};

        // one byte of range / 255 per cycle, remainder stays below 255
        scl_n   = {rem_reg, range_reg[{scl_cnt_reg, 3'b000} +: 8]};
        scl_sum = scl_n + {8'h00, scl_n[15:8]} + 16'd1;
        scl_q   = scl_sum[15:8];
        scl_rem = scl_n - {scl_q, 8'h00} + {8'h00, scl_q};

        emit_idx_next = emit_idx_reg + 1'b1;
        is_last       = (emit_idx_next == fill_cnt_reg);
        slot_free     = !code_valid_reg || !code_stall;
        xfer          = (state_reg == S_WAIT) && div_done && slot_free;

        // read the first entry while the scale finishes, the next one at each hand-off
        rd_en   = (state_reg == S_SCALE_ADD) || (xfer && !is_last);
        rd_addr = (state_reg == S_SCALE_ADD) ? '0 : emit_idx_next[ADDR_W-1:0];

        diff_wide = {rd_data[DATA_W-1], rd_data} - {min_reg[DATA_W-1], min_reg};

        div_ctrl.start = (state_reg == S_START);
        div_ctrl.take  = xfer;
    end

    rmq_row_mem #(
        .DEPTH  (ROW_LEN_MAX),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (fill_cnt_reg[ADDR_W-1:0]),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rmq_code_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .diff  (diff_wide[DATA_W-1:0]),
        .range (range_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_FILL;
            fill_cnt_reg    <= '0;
            emit_idx_reg    <= '0;
            min_reg         <= MIN_INIT;
            max_reg         <= MAX_INIT;
            range_reg       <= '0;
            qacc_reg        <= '0;
            rem_reg         <= '0;
            scl_cnt_reg     <= '0;
            scale_reg       <= '0;
            code_valid_reg  <= 1'b0;
            code_reg        <= '0;
            code_scale_reg  <= '0;
            code_offset_reg <= '0;
            last_code_reg   <= 1'b0;
        end
        else
        begin
            // a hand-off in the same cycle refills the slot
            if (code_valid_reg && !code_stall && !xfer)
            begin
                code_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_FILL:
                begin
                    if (accept)
                    begin
                        fill_cnt_reg <= fill_cnt_next;
                        min_reg      <= min_next;
                        max_reg      <= max_next;
                        if (row_end)
                        begin
                            state_reg <= S_RANGE;
                        end
                    end
                end
                S_RANGE:
                begin
                    range_reg   <= range_wide[DATA_W-1:0];
                    qacc_reg    <= '0;
                    rem_reg     <= '0;
                    scl_cnt_reg <= 2'd3;
                    state_reg   <= S_SCALE;
                end
                S_SCALE:
                begin
                    qacc_reg    <= {qacc_reg[DATA_W-9:0], scl_q};
                    rem_reg     <= scl_rem[7:0];
                    scl_cnt_reg <= scl_cnt_reg - 1'b1;
                    if (scl_cnt_reg == 2'd0)
                    begin
                        state_reg <= S_SCALE_ADD;
                    end
                end
                S_SCALE_ADD:
                begin
                    // range * 256 / 255 = range + range / 255
                    scale_reg    <= {1'b0, range_reg} + {1'b0, qacc_reg};
                    emit_idx_reg <= '0;
                    state_reg    <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (xfer)
                    begin
                        code_valid_reg  <= 1'b1;
                        code_reg        <= div_quot;
                        code_scale_reg  <= scale_reg;
                        code_offset_reg <= min_reg;
                        last_code_reg   <= is_last;
                        if (is_last)
                        begin
                            fill_cnt_reg <= '0;
                            min_reg      <= MIN_INIT;
                            max_reg      <= MAX_INIT;
                            state_reg    <= S_FILL;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_next;
                            state_reg    <= S_START;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_FILL;
                end
            endcase
        end
    end

    assign sample_stall = (state_reg != S_FILL);
    assign code_valid   = code_valid_reg;
    assign code         = code_reg;
    assign scale        = code_scale_reg;
    assign row_offset   = code_offset_reg;
    assign last_code    = last_code_reg;

    `RMQ_ASSERT_IMPL(a_min_le_max, clk, rst_n, fill_cnt_reg != '0,
        $signed(min_reg) <= $signed(max_reg), "row minimum above row maximum")
    `RMQ_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1,
        fill_cnt_reg <= CNT_W'(ROW_LEN_MAX), "fill count beyond buffer depth")
    `RMQ_ASSERT_IMPL(a_emit_in_row, clk, rst_n, state_reg == S_START || state_reg == S_WAIT,
        emit_idx_reg < fill_cnt_reg, "emit index outside the stored row")
    `RMQ_ASSERT_NEXT(a_last_ends_row, clk, rst_n, xfer && is_last,
        state_reg == S_FILL && fill_cnt_reg == '0, "row not cleared after its last code")

endmodule
